// File: hdl/saturating_infinity_alu_unit_macros.svh
// Assertion macros for the saturating arithmetic unit.
`ifndef SATURATING_INFINITY_ALU_UNIT_MACROS_SVH
`define SATURATING_INFINITY_ALU_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define SIA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SIA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define SIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: hdl/sia_pkg.sv
package sia_pkg;

    localparam logic signed [31:0] INFV = 32'sd2147483647;
    localparam logic signed [31:0] MAXV = 32'sd2000000000;

    localparam int DIV_DW    = 64;
    localparam int DIV_DV    = 32;
    localparam int DIV_LANES = 4;
    localparam int DIV_BPS   = 2;

    localparam int LANE_AD = 0;
    localparam int LANE_MN = 1;
    localparam int LANE_HD = 2;
    localparam int LANE_PD = 3;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_ADD   = 2'd1,
        MODE_SUB   = 2'd2,
        MODE_SCALE = 2'd3
    } t_mode;

    typedef logic [DIV_DW-1:0] t_dw;
    typedef logic [DIV_DV-1:0] t_dv;

    typedef struct packed {
        logic               fast;
        logic signed [31:0] fast_val;
        logic [31:0]        a_mag;
        logic               a_zero;
        logic               a_neg;
        logic               n_neg;
        logic               d_neg;
        logic               hd_neg;
        logic [31:0]        lo_mag;
        logic               lo_neg;
    } t_side;

endpackage

// File: hdl/sia_if.sv
interface sia_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         mode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic signed [31:0] scale_num;
    logic signed [31:0] scale_denom;

    modport source(output valid, mode, operand_a, operand_b, scale_num, scale_denom,
                   input ready);
    modport sink(input valid, mode, operand_a, operand_b, scale_num, scale_denom,
                 output ready);
endinterface

interface sia_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result;
    logic               is_infinite;
    logic               is_saturated;

    modport source(output valid, result, is_infinite, is_saturated, input ready);
    modport sink(input valid, result, is_infinite, is_saturated, output ready);
endinterface

// File: hdl/saturating_infinity_alu_unit.sv
// Saturating 32-bit arithmetic with infinities: load, add, subtract and scale by num/denom.
// One transaction enters per cycle while the output is not stalled; a result passes through the
// entry, decode, divider, branch and output registers, the divider being a restoring divider that
// retires DIV_BITS_PER_STAGE quotient bits per stage over a 64-bit dividend. A stall at the output
// freezes the whole pipeline, so nothing is lost or repeated.
`include "saturating_infinity_alu_unit_macros.svh"

module saturating_infinity_alu_unit #(
    parameter int DIV_BITS_PER_STAGE = sia_pkg::DIV_BPS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    sia_in_if.sink     i_in,
    sia_out_if.source  o_out
);
    import sia_pkg::*;

    function automatic logic signed [31:0] clamp(input logic signed [31:0] v);
        if (v == INFV || v == -INFV || (v >= -MAXV && v <= MAXV)) return v;
        return (v > 0) ? MAXV : -MAXV;
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (a == INFV) return (b == -INFV) ? 32'sd0 : a;
        if (a == -INFV) return (b == INFV) ? 32'sd0 : a;
        if (b == INFV || b == -INFV) return b;
        if (!b[31]) return (s >= 33'(MAXV)) ? MAXV : s[31:0];
        return (s <= -33'(MAXV)) ? -MAXV : s[31:0];
    endfunction

    logic w_en;
    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    // clamp on entry
    logic               r_a_valid;
    logic [1:0]         r_a_mode;
    logic signed [31:0] r_a_a, r_a_b, r_a_n, r_a_d;
    logic [31:0]        r_a_amag, r_a_nmag, r_a_dmag;
    logic signed [31:0] n_a_a;

    assign n_a_a = clamp(i_in.operand_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_valid <= 1'b0;
        else if (w_en) r_a_valid <= i_in.valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_mode <= i_in.mode;
            r_a_a    <= n_a_a;
            r_a_b    <= clamp(i_in.operand_b);
            r_a_n    <= i_in.scale_num;
            r_a_d    <= i_in.scale_denom;
            r_a_amag <= mag(n_a_a);
            r_a_nmag <= mag(i_in.scale_num);
            r_a_dmag <= mag(i_in.scale_denom);
        end
    end

    // mode decode, early scale cases, product
    t_side              n_b_side;
    logic signed [31:0] w_hi, w_lo;

    always_comb begin
        logic ainf;
        ainf = (r_a_a == INFV) || (r_a_a == -INFV);
        w_hi = (r_a_n > r_a_a) ? r_a_n : r_a_a;
        w_lo = (r_a_n < r_a_a) ? r_a_n : r_a_a;

        n_b_side.fast     = 1'b1;
        n_b_side.fast_val = '0;
        n_b_side.a_mag    = r_a_amag;
        n_b_side.a_zero   = (r_a_a == 32'sd0);
        n_b_side.a_neg    = r_a_a[31];
        n_b_side.n_neg    = r_a_n[31];
        n_b_side.d_neg    = r_a_d[31];
        n_b_side.hd_neg   = w_hi[31] ^ r_a_d[31];
        n_b_side.lo_mag   = mag(w_lo);
        n_b_side.lo_neg   = w_lo[31];

        unique case (t_mode'(r_a_mode))
            MODE_LOAD: n_b_side.fast_val = r_a_b;
            MODE_ADD:  n_b_side.fast_val = sat_add(r_a_a, r_a_b);
            MODE_SUB:  n_b_side.fast_val = sat_add(r_a_a, -r_a_b);
            MODE_SCALE: begin
                if (ainf) begin
                    n_b_side.fast_val = (r_a_n[31] ^ r_a_d[31]) ? -r_a_a : r_a_a;
                end else if (r_a_n == 32'sd0) begin
                    n_b_side.fast_val = '0;
                end else if (r_a_d == 32'sd0) begin
                    n_b_side.fast_val = (r_a_n[31] ^ r_a_a[31]) ? -INFV : INFV;
                end else if (r_a_a == MAXV || (r_a_a == -MAXV && r_a_n >= r_a_d)) begin
                    n_b_side.fast_val = (r_a_n[31] ^ r_a_d[31]) ? -MAXV : MAXV;
                end else begin
                    n_b_side.fast = 1'b0;
                end
            end
            default: n_b_side.fast_val = r_a_b;
        endcase
    end

    logic        r_b_valid;
    t_side       r_b_side;
    logic [63:0] r_b_prod;
    logic [31:0] r_b_amag, r_b_nmag, r_b_dmag, r_b_himag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_b_valid <= 1'b0;
        else if (w_en) r_b_valid <= r_a_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_side  <= n_b_side;
            r_b_prod  <= r_a_amag * r_a_nmag;
            r_b_amag  <= r_a_amag;
            r_b_nmag  <= r_a_nmag;
            r_b_dmag  <= r_a_dmag;
            r_b_himag <= mag(w_hi);
        end
    end

    // quotients of magnitudes
    t_dw   w_dividend [DIV_LANES];
    t_dv   w_divisor  [DIV_LANES];
    t_dw   w_quot     [DIV_LANES];
    logic  w_div_valid;
    t_side w_div_side;

    always_comb begin
        w_dividend[LANE_AD] = t_dw'(r_b_amag);
        w_divisor[LANE_AD]  = r_b_dmag;
        w_dividend[LANE_MN] = t_dw'(MAXV);
        w_divisor[LANE_MN]  = r_b_nmag;
        w_dividend[LANE_HD] = t_dw'(r_b_himag);
        w_divisor[LANE_HD]  = r_b_dmag;
        w_dividend[LANE_PD] = r_b_prod;
        w_divisor[LANE_PD]  = r_b_dmag;
    end

    sia_div_pipe #(
        .BPS(DIV_BITS_PER_STAGE)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (r_b_valid),
        .i_side     (r_b_side),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_valid    (w_div_valid),
        .o_side     (w_div_side),
        .o_quot     (w_quot)
    );

    // branch conditions and approximation product
    logic        r_c_valid;
    t_side       r_c_side;
    logic        r_c_condb, r_c_condc, r_c_vneg;
    logic [63:0] r_c_vmag;
    logic [31:0] r_c_emag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_c_valid <= 1'b0;
        else if (w_en) r_c_valid <= w_div_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_side  <= w_div_side;
            r_c_condb <= (w_quot[LANE_AD] >= w_quot[LANE_MN]);
            r_c_condc <= (w_quot[LANE_MN] <= t_dw'(w_div_side.a_mag));
            r_c_vmag  <= w_quot[LANE_HD][31:0] * w_div_side.lo_mag;
            r_c_vneg  <= w_div_side.hd_neg ^ w_div_side.lo_neg;
            r_c_emag  <= w_quot[LANE_PD][31:0];
        end
    end

    // final selection
    logic signed [31:0] n_res;

    always_comb begin
        logic        neg;
        logic [31:0] m;
        neg = r_c_side.a_neg ^ r_c_side.n_neg ^ r_c_side.d_neg;
        m   = (r_c_vmag > 64'(MAXV)) ? MAXV : r_c_vmag[31:0];
        if (r_c_side.fast) begin
            n_res = r_c_side.fast_val;
        end else if (r_c_condb) begin
            n_res = r_c_side.a_zero ? 32'sd0 : (neg ? -MAXV : MAXV);
        end else if (r_c_condc) begin
            n_res = r_c_vneg ? -m : m;
        end else begin
            n_res = neg ? -r_c_emag : r_c_emag;
        end
    end

    logic               r_o_valid, r_o_inf, r_o_sat;
    logic signed [31:0] r_o_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_o_valid <= 1'b0;
        else if (w_en) r_o_valid <= r_c_valid;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_result <= n_res;
            r_o_inf    <= (n_res == INFV) || (n_res == -INFV);
            r_o_sat    <= (n_res == MAXV) || (n_res == -MAXV);
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.result       = r_o_result;
    assign o_out.is_infinite  = r_o_inf;
    assign o_out.is_saturated = r_o_sat;

    `SIA_ASSERT_IMPLY(a_flags_excl, i_clk, i_rst_n, o_out.valid, !(o_out.is_infinite && o_out.is_saturated))
    `SIA_ASSERT_IMPLY(a_inf_code, i_clk, i_rst_n, o_out.valid && o_out.is_infinite, o_out.result == INFV || o_out.result == -INFV)
    `SIA_ASSERT_NEXT(a_div_hold, i_clk, i_rst_n, w_div_valid && !w_en, w_div_valid && $stable(w_div_side))

endmodule

// File: hdl/sia_div_pipe.sv
module sia_div_pipe #(
    parameter int BPS = sia_pkg::DIV_BPS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  sia_pkg::t_side i_side,
    input  sia_pkg::t_dw   i_dividend [sia_pkg::DIV_LANES],
    input  sia_pkg::t_dv   i_divisor  [sia_pkg::DIV_LANES],
    output logic           o_valid,
    output sia_pkg::t_side o_side,
    output sia_pkg::t_dw   o_quot     [sia_pkg::DIV_LANES]
);
    import sia_pkg::*;

    localparam int STAGES = DIV_DW / BPS;

    logic  r_valid [STAGES];
    t_side r_side  [STAGES];
    t_dw   r_x     [STAGES][DIV_LANES];
    t_dv   r_rem   [STAGES][DIV_LANES];
    t_dv   r_d     [STAGES][DIV_LANES];

    logic  src_valid [STAGES];
    t_side src_side  [STAGES];
    t_dw   src_x     [STAGES][DIV_LANES];
    t_dv   src_rem   [STAGES][DIV_LANES];
    t_dv   src_d     [STAGES][DIV_LANES];

    t_dw   n_x   [STAGES][DIV_LANES];
    t_dv   n_rem [STAGES][DIV_LANES];

    always_comb begin
        src_valid[0] = i_valid;
        src_side[0]  = i_side;
        for (int l = 0; l < DIV_LANES; l++) begin
            src_x[0][l]   = i_dividend[l];
            src_rem[0][l] = '0;
            src_d[0][l]   = i_divisor[l];
        end
        for (int s = 1; s < STAGES; s++) begin
            src_valid[s] = r_valid[s-1];
            src_side[s]  = r_side[s-1];
            src_x[s]     = r_x[s-1];
            src_rem[s]   = r_rem[s-1];
            src_d[s]     = r_d[s-1];
        end
    end

    always_comb begin
        logic [DIV_DV:0] t;
        t_dw             x;
        t_dv             rem;
        for (int s = 0; s < STAGES; s++) begin
            for (int l = 0; l < DIV_LANES; l++) begin
                x   = src_x[s][l];
                rem = src_rem[s][l];
                for (int b = 0; b < BPS; b++) begin
                    t = {rem, x[DIV_DW-1]};
                    x = {x[DIV_DW-2:0], 1'b0};
                    if (t >= {1'b0, src_d[s][l]}) begin
                        t    = t - {1'b0, src_d[s][l]};
                        x[0] = 1'b1;
                    end
                    rem = t[DIV_DV-1:0];
                end
                n_x[s][l]   = x;
                n_rem[s][l] = rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < STAGES; s++) r_valid[s] <= 1'b0;
        end else if (i_en) begin
            r_valid <= src_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side <= src_side;
            r_x    <= n_x;
            r_rem  <= n_rem;
            r_d    <= src_d;
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_side  = r_side[STAGES-1];
    assign o_quot  = r_x[STAGES-1];

endmodule

// File: dv/sia_result_checker.sv
`timescale 1ns / 100ps

module sia_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    sia_in_if    i_in,
    sia_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import sia_pkg::*;

    typedef struct packed {
        logic signed [31:0] result;
        logic               is_infinite;
        logic               is_saturated;
    } t_alu_result;

    localparam longint LINF = longint'(INFV);
    localparam longint LMAX = longint'(MAXV);

    t_alu_result expected_results[$];

    function automatic longint sign_of(longint v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic longint abs_of(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint clamp_value(longint v);
        if (v == LINF || v == -LINF || (v >= -LMAX && v <= LMAX))
            return v;
        return LMAX * sign_of(v);
    endfunction

    function automatic longint saturating_sum(longint a, longint b);
        if (a == LINF)
            return (b == -LINF) ? 0 : a;
        if (a == -LINF)
            return (b == LINF) ? 0 : a;
        if (b == LINF || b == -LINF)
            return b;
        if (b >= 0)
            return (LMAX - b <= a) ? LMAX : a + b;
        return (-LMAX - b >= a) ? -LMAX : a + b;
    endfunction

    function automatic longint scaled_value(longint a, longint n, longint d);
        longint hi;
        longint lo;
        longint v;
        if (a == LINF || a == -LINF) begin
            if (n != 0)
                a = a * sign_of(n);
            if (d != 0)
                a = a * sign_of(d);
            return a;
        end
        if (n == 0)
            return 0;
        if (d == 0)
            return (a != 0) ? LINF * sign_of(n) * sign_of(a) : LINF * sign_of(n);
        if (a == LMAX || (a == -LMAX && n >= d))
            return LMAX * sign_of(n) * sign_of(d);
        if (abs_of(a) / abs_of(d) >= LMAX / abs_of(n))
            return LMAX * sign_of(a) * sign_of(n) * sign_of(d);
        if (LMAX / abs_of(n) <= abs_of(a)) begin
            hi = (n > a) ? n : a;
            lo = (n < a) ? n : a;
            v  = (hi / d) * lo;
            if (v > LMAX)
                v = LMAX;
            if (v < -LMAX)
                v = -LMAX;
            return v;
        end
        return (a * n) / d;
    endfunction

    function automatic t_alu_result predict_result(logic [1:0] mode, logic signed [31:0] opa,
                                                   logic signed [31:0] opb,
                                                   logic signed [31:0] num,
                                                   logic signed [31:0] den);
        t_alu_result res;
        longint a;
        longint b;
        longint r;
        a = clamp_value(longint'(opa));
        b = clamp_value(longint'(opb));
        case (t_mode'(mode))
            MODE_LOAD:  r = b;
            MODE_ADD:   r = saturating_sum(a, b);
            MODE_SUB:   r = saturating_sum(a, clamp_value(-b));
            default:    r = scaled_value(a, longint'(num), longint'(den));
        endcase
        res.result       = r[31:0];
        res.is_infinite  = (r == LINF || r == -LINF);
        res.is_saturated = (r == LMAX || r == -LMAX);
        return res;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_alu_result want;
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                expected_results.push_back(predict_result(i_in.mode, i_in.operand_a,
                    i_in.operand_b, i_in.scale_num, i_in.scale_denom));
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result %0d arrived with nothing expected", i_out.result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out.result !== want.result || i_out.is_infinite !== want.is_infinite
                        || i_out.is_saturated !== want.is_saturated) begin
                        if (i_out.result !== want.result)
                            $error("result: expected %0d, actual %0d", want.result,
                                   i_out.result);
                        if (i_out.is_infinite !== want.is_infinite)
                            $error("is_infinite: expected %0b, actual %0b",
                                   want.is_infinite, i_out.is_infinite);
                        if (i_out.is_saturated !== want.is_saturated)
                            $error("is_saturated: expected %0b, actual %0b",
                                   want.is_saturated, i_out.is_saturated);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sia_pkg::*;

    localparam int NUM_RANDOM     = 1200;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 80;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    int   sent_count;
    bit   hold_request;

    sia_in_if  in_if ();
    sia_out_if out_if ();

    saturating_infinity_alu_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    sia_result_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_if),
        .i_out        (out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] pick_operand();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
            2:       v = $urandom_range(0, 1) ? MAXV : -MAXV;
            3:       v = MAXV + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
            4:       v = $urandom_range(0, 1) ? INFV : -INFV;
            5:       v = 32'sh8000_0000;
            6, 7:    v = $urandom;
            default: v = $signed($urandom_range(0, 4000)) - 32'sd2000;
        endcase
        if ($urandom_range(0, 1) && v != 32'sh8000_0000 && $urandom_range(0, 2) == 0)
            v = -v;
        return v;
    endfunction

    task automatic send_operation(input t_mode mode, input logic signed [31:0] opa,
                                  input logic signed [31:0] opb,
                                  input logic signed [31:0] num,
                                  input logic signed [31:0] den);
        in_if.valid       <= 1'b1;
        in_if.mode        <= mode;
        in_if.operand_a   <= opa;
        in_if.operand_b   <= opb;
        in_if.scale_num   <= num;
        in_if.scale_denom <= den;
        do @(negedge i_clk); while (!in_if.ready);
        @(posedge i_clk);
        sent_count++;
    endtask

    task automatic idle_sender(input int cycles);
        in_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int hold;
        out_if.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_if.ready <= 1'b0;
                for (hold = 0; hold < 250; hold++)
                    @(posedge i_clk);
            end
            if ($urandom_range(0, 4) == 0)
                out_if.ready <= 1'b0;
            else
                out_if.ready <= 1'b1;
        end
    end

    initial begin
        int gap;
        int waited;
        bit burst;
        idle_cycles  = 0;
        sent_count   = 0;
        hold_request = 1'b0;
        i_rst_n           <= 1'b0;
        in_if.valid       <= 1'b0;
        in_if.mode        <= MODE_LOAD;
        in_if.operand_a   <= '0;
        in_if.operand_b   <= '0;
        in_if.scale_num   <= '0;
        in_if.scale_denom <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_operation(MODE_LOAD,  0, 32'sh8000_0000, 0, 0);
        send_operation(MODE_LOAD,  0, MAXV + 1, 0, 0);
        send_operation(MODE_LOAD,  0, -INFV, 0, 0);
        send_operation(MODE_ADD,   INFV, -INFV, 0, 0);
        send_operation(MODE_ADD,   -INFV, INFV, 0, 0);
        send_operation(MODE_ADD,   5, INFV, 0, 0);
        send_operation(MODE_ADD,   MAXV - 10, 10, 0, 0);
        send_operation(MODE_ADD,   -MAXV + 3, -7, 0, 0);
        send_operation(MODE_SUB,   INFV, INFV, 0, 0);
        send_operation(MODE_SUB,   -100, 32'sh8000_0000, 0, 0);
        send_operation(MODE_SUB,   32'sh7FFF_FFF0, -5, 0, 0);
        send_operation(MODE_SCALE, -INFV, -3, 0, 5);
        send_operation(MODE_SCALE, INFV, 0, 0, 0);
        send_operation(MODE_SCALE, 1234, 0, 0, 7);
        send_operation(MODE_SCALE, -55, 0, 3, 0);
        send_operation(MODE_SCALE, 0, 0, -3, 0);
        send_operation(MODE_SCALE, MAXV, 0, -2, 3);
        send_operation(MODE_SCALE, -MAXV, 0, 5, 4);
        send_operation(MODE_SCALE, -MAXV, 0, 4, 5);
        send_operation(MODE_SCALE, 1000000, 0, 3000, 1);
        send_operation(MODE_SCALE, 1500000, 0, 2000, 3);
        send_operation(MODE_SCALE, -12345, 0, 77, -9);
        send_operation(MODE_SCALE, 32'sh8000_0000, 0, 32'sh8000_0000, 32'sh8000_0000);
        send_operation(MODE_SCALE, 7, 0, 2147483647, -1);

        burst = 1'b0;
        for (int i = 0; i < NUM_RANDOM; i++) begin
            if (i % 100 == 0)
                burst = ($urandom_range(0, 2) == 0);
            if (i == 300) begin
                burst = 1'b1;
                hold_request = 1'b1;
            end
            if (i == 700) begin
                in_if.valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            send_operation(t_mode'($urandom_range(0, 3)), pick_operand(), pick_operand(),
                           $urandom_range(0, 2) == 0 ? $urandom : pick_operand(),
                           $urandom_range(0, 2) == 0 ? $urandom : pick_operand());
            if (!burst && $urandom_range(0, 3) == 0) begin
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                  : $urandom_range(1, 3);
                idle_sender(gap);
            end
        end
        in_if.valid <= 1'b0;

        waited = 0;
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d operations sent over load, add, subtract and scale,", sent_count);
        $display("with infinity, saturation and division corners and long output stalls.");
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
